@@ design/mssm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register codes and helpers for the soft-sphere move block.
package mssm_pkg;

	localparam int MAX_SPHERES_DEF = 256;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 31;
	localparam int POS_W           = 32;
	localparam int E_W             = 48;
	localparam int DRAW_W          = 32;

	localparam logic [32:0] P_ONE     = 33'h1_0000_0000;
	localparam logic [30:0] INV_E_Q32 = 31'd1580030169;
	localparam logic [33:0] FOUR_Q16  = 34'h0_0004_0000;
	localparam logic [35:0] FOUR_Q32  = 36'h4_0000_0000;
	localparam logic [17:0] TWO_Q16   = 18'h2_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_X   = 3'd0,
		CFG_BOX_Y   = 3'd1,
		CFG_BOX_Z   = 3'd2,
		CFG_KT      = 3'd3,
		CFG_MODE    = 3'd4,
		CFG_OUTER_R = 3'd5,
		CFG_INNER_R = 3'd6,
		CFG_COUNT   = 3'd7
	} cfg_reg_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		return v[33] ? 34'(-v) : 34'(v);
	endfunction

endpackage

@@ design/mssm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mssm_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/metropolis_soft_sphere_move.sv @@
`timescale 1ns / 1ps
// Metropolis soft-sphere move: position store, wall test, pair energy sums and acceptance.
//
// Input channel (in_valid/in_ready) takes one request: a load writes one sphere position,
// a move proposes a new position for one sphere. Every request gives exactly one result
// on the output channel (out_valid/out_ready): accepted flag and the old and new energy.
// The block takes one request at a time; in_ready is high only while it is idle.
// A load or an out-of-range index goes from idle straight to the final state and the output.
// A move first runs the wall test (one shared 33x33 multiplier, one product a cycle),
// then two passes over the stored spheres: per other sphere a RAM read, then a range
// check per periodic image, and for each image in range 3 squares, an 18-step square
// root, 1 square and 1 accumulate. A rise in energy adds a 64-step divide and, unless
// the exponent is 32 or more, 14 series terms of 1 multiply and a 64-step divide each,
// plus one multiply by 1/e per whole unit of the exponent. The pair loop and the shared
// divider set the duration of a move.
// Configuration writes on cfg_we take effect at once; write only while idle.
// Reset clears the control state and the configuration registers to their defaults; the
// position store is not cleared. When the receiver stalls, the result holds in the output
// register; the block still goes idle, and the next result waits until it is taken.
module metropolis_soft_sphere_move #(
	parameter int MAX_SPHERES = mssm_pkg::MAX_SPHERES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mssm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mssm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [7:0]                            sphere_index,
	input  logic signed [mssm_pkg::POS_W-1:0]     pos_x,
	input  logic signed [mssm_pkg::POS_W-1:0]     pos_y,
	input  logic signed [mssm_pkg::POS_W-1:0]     pos_z,
	input  logic [mssm_pkg::DRAW_W-1:0]           uniform_draw,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  accepted,
	output logic [mssm_pkg::E_W-1:0]              energy_before,
	output logic [mssm_pkg::E_W-1:0]              energy_after
);

	import mssm_pkg::*;

	localparam int AW = $clog2(MAX_SPHERES);
	localparam int CW = $clog2(MAX_SPHERES + 1);

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_WALL  = 19'h00002,
		S_RDS   = 19'h00004,
		S_OLDC  = 19'h00008,
		S_RD    = 19'h00010,
		S_GET   = 19'h00020,
		S_IMG   = 19'h00040,
		S_SQ    = 19'h00080,
		S_SQRT  = 19'h00100,
		S_TERM  = 19'h00200,
		S_ACC   = 19'h00400,
		S_CMP   = 19'h00800,
		S_DIV   = 19'h01000,
		S_EMUL  = 19'h02000,
		S_EDIV  = 19'h04000,
		S_EPOW  = 19'h08000,
		S_EPOW2 = 19'h10000,
		S_DRAW  = 19'h20000,
		S_FIN   = 19'h40000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	logic [30:0] box_q [3];
	logic [30:0] kt_q, outer_r_q, inner_r_q;
	logic [7:0]  mode_q;
	logic [8:0]  count_q;

	logic              wr_q, ok_q, pass_q, dmode_q;
	logic [7:0]        s_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] c_q [3];
	logic signed [31:0] o_q [3];
	logic [1:0]        sh_q [3];
	logic [16:0]       da_q [3];
	logic [DRAW_W-1:0] draw_q;
	logic [5:0]        cnt_q;
	logic [CW-1:0]     i_q;
	logic [63:0]       wr2_q;
	logic [61:0]       ro2_q;
	logic [35:0]       sq_acc_q, sq_x_q, sq_r_q, sq_b_q;
	logic [E_W-1:0]    en_acc_q, e_old_q, e_new_q;
	logic [63:0]       div_n_q;
	logic [30:0]       div_r_q, div_d_q;
	logic [32:0]       term_q, p_q;
	logic signed [34:0] ex_acc_q;
	logic [4:0]        m_q;
	logic [15:0]       f_q;
	logic [3:0]        k_q;
	logic [65:0]       prod_q;
	logic              out_acc_q;
	logic [E_W-1:0]    out_eb_q, out_ea_q;

	logic [32:0] mul_a, mul_b;
	logic [2:0]  act, walls;
	logic [1:0]  first_sh [3];
	logic [1:0]  nsh [3];
	logic        img_last, far;
	logic [33:0] dmag_w [3];
	logic        i_done, i_is_s, s_ok_in, fin_go, wall_rej, sq_big, sq_ge, div_ge;
	logic [35:0] sq_sum, sq_x_n, sq_r_n;
	logic [36:0] sq_t;
	logic [31:0] div_trial, div_sub;
	logic [30:0] div_r_n;
	logic [63:0] div_n_n;
	logic        m_big;
	logic signed [34:0] ex_acc_n;
	logic [32:0] p_clamp, p_round;
	logic [64:0] round_sum;
	logic [48:0] en_sum;
	logic [E_W-1:0] en_sat;
	logic [95:0] ram_rdata;
	logic        ram_we;
	logic [AW-1:0] ram_raddr;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign accepted      = out_acc_q;
	assign energy_before = out_eb_q;
	assign energy_after  = out_ea_q;

	assign s_ok_in = 32'(sphere_index) < 32'(MAX_SPHERES);
	assign i_done  = (32'(i_q) >= 32'(count_q)) || (32'(i_q) >= 32'(MAX_SPHERES));
	assign i_is_s  = 32'(i_q) == 32'(s_q);
	assign fin_go  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			act[a] = mode_q[a] &&
				(({1'b0, mag32(c_q[a]), 1'b0} + FOUR_Q16) >= {3'b000, box_q[a]});
			walls[a] = mode_q[3+a] && ({mag32(pos_q[a]), 1'b0} > {2'b00, box_q[a]});
			first_sh[a] = act[a] ? 2'b11 : 2'b00;
			dmag_w[a] = mag34($signed({{2{o_q[a][31]}}, o_q[a]})
				+ ((sh_q[a] == 2'b01) ? $signed({3'b000, box_q[a]}) :
				   (sh_q[a] == 2'b11) ? -$signed({3'b000, box_q[a]}) : 34'sd0)
				- $signed({{2{c_q[a][31]}}, c_q[a]}));
		end
		far = (dmag_w[0][33:17] != '0) || (dmag_w[1][33:17] != '0) ||
			(dmag_w[2][33:17] != '0);
	end

	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int a = 2; a >= 0; a--) begin
			if (!carry) begin
				nsh[a] = sh_q[a];
			end else if (act[a] && sh_q[a] != 2'b01) begin
				nsh[a] = sh_q[a] + 2'b01;
				carry  = 1'b0;
			end else begin
				nsh[a] = first_sh[a];
			end
		end
		img_last = carry;
	end

	assign wall_rej = (mode_q[6] && wr2_q > {2'b00, ro2_q}) ||
		(mode_q[7] && wr2_q < {2'b00, prod_q[61:0]}) || (walls != '0);

	assign sq_sum = sq_acc_q + prod_q[35:0];
	assign sq_big = sq_sum >= FOUR_Q32;
	assign sq_t   = {1'b0, sq_r_q} + {1'b0, sq_b_q};
	assign sq_ge  = {1'b0, sq_x_q} >= sq_t;
	assign sq_x_n = sq_ge ? sq_x_q - sq_t[35:0] : sq_x_q;
	assign sq_r_n = sq_ge ? (sq_r_q >> 1) + sq_b_q : (sq_r_q >> 1);

	assign en_sum = {1'b0, en_acc_q} + {32'b0, prod_q[34:18]};
	assign en_sat = en_sum[48] ? '1 : en_sum[47:0];

	assign div_trial = {div_r_q, div_n_q[63]};
	assign div_ge    = div_trial >= {1'b0, div_d_q};
	assign div_sub   = div_trial - {1'b0, div_d_q};
	assign div_r_n   = div_ge ? div_sub[30:0] : div_trial[30:0];
	assign div_n_n   = {div_n_q[62:0], div_ge};
	assign m_big     = div_n_n[63:21] != '0;

	assign ex_acc_n = k_q[0] ? ex_acc_q - $signed({2'b00, div_n_n[32:0]})
		: ex_acc_q + $signed({2'b00, div_n_n[32:0]});
	assign p_clamp  = ex_acc_n[34] ? 33'd0 :
		(ex_acc_n[33:0] > {1'b0, P_ONE}) ? P_ONE : ex_acc_n[32:0];
	assign round_sum = {1'b0, prod_q[63:0]} + 65'h0_8000_0000;
	assign p_round   = round_sum[64:32];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_WALL: begin
				case (cnt_q)
					6'd0: begin mul_a = {1'b0, mag32(pos_q[0])}; mul_b = mul_a; end
					6'd1: begin mul_a = {1'b0, mag32(pos_q[1])}; mul_b = mul_a; end
					6'd2: begin mul_a = {1'b0, mag32(pos_q[2])}; mul_b = mul_a; end
					6'd3: begin mul_a = {2'b00, outer_r_q}; mul_b = mul_a; end
					6'd4: begin mul_a = {2'b00, inner_r_q}; mul_b = mul_a; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_SQ: begin
				case (cnt_q)
					6'd0: begin mul_a = {16'b0, da_q[0]}; mul_b = mul_a; end
					6'd1: begin mul_a = {16'b0, da_q[1]}; mul_b = mul_a; end
					6'd2: begin mul_a = {16'b0, da_q[2]}; mul_b = mul_a; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_TERM: begin
				mul_a = {15'b0, TWO_Q16 - sq_r_q[17:0]};
				mul_b = mul_a;
			end
			S_EMUL: begin
				mul_a = term_q;
				mul_b = {17'b0, f_q};
			end
			S_EPOW: begin
				mul_a = p_q;
				mul_b = {2'b00, INV_E_Q32};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				state_d = (!s_ok_in || !action) ? S_FIN : S_WALL;
			end
			S_WALL: if (cnt_q == 6'd5) begin
				state_d = wall_rej ? S_FIN : S_RDS;
			end
			S_RDS: state_d = S_OLDC;
			S_OLDC: state_d = S_RD;
			S_RD: begin
				if (i_done) begin
					state_d = pass_q ? S_CMP : S_RD;
				end else if (!i_is_s) begin
					state_d = S_GET;
				end
			end
			S_GET: state_d = S_IMG;
			S_IMG: begin
				if (far) begin
					state_d = img_last ? S_RD : S_IMG;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: if (cnt_q == 6'd3) begin
				state_d = !sq_big ? S_SQRT : (img_last ? S_RD : S_IMG);
			end
			S_SQRT: if (sq_b_q[0]) begin
				state_d = S_TERM;
			end
			S_TERM: state_d = S_ACC;
			S_ACC: state_d = img_last ? S_RD : S_IMG;
			S_CMP: state_d = (e_new_q <= e_old_q) ? S_FIN : S_DIV;
			S_DIV: if (cnt_q == 6'd63) begin
				if (dmode_q) begin
					state_d = (k_q == 4'd14) ? S_EPOW : S_EMUL;
				end else begin
					state_d = m_big ? S_DRAW : S_EMUL;
				end
			end
			S_EMUL: state_d = S_EDIV;
			S_EDIV: state_d = S_DIV;
			S_EPOW: state_d = (m_q == '0) ? S_DRAW : S_EPOW2;
			S_EPOW2: state_d = S_EPOW;
			S_DRAW: state_d = S_FIN;
			S_FIN: if (fin_go) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			box_q[0]    <= 31'd1310720;
			box_q[1]    <= 31'd1310720;
			box_q[2]    <= 31'd1310720;
			kt_q        <= 31'd65536;
			mode_q      <= '0;
			outer_r_q   <= 31'd655360;
			inner_r_q   <= 31'd196608;
			count_q     <= 9'd1;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BOX_X:   box_q[0]  <= cfg_data;
					CFG_BOX_Y:   box_q[1]  <= cfg_data;
					CFG_BOX_Z:   box_q[2]  <= cfg_data;
					CFG_KT:      kt_q      <= cfg_data;
					CFG_MODE:    mode_q    <= cfg_data[7:0];
					CFG_OUTER_R: outer_r_q <= cfg_data;
					CFG_INNER_R: inner_r_q <= cfg_data;
					CFG_COUNT:   count_q   <= cfg_data[8:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: if (in_valid) begin
				s_q      <= sphere_index;
				pos_q[0] <= pos_x;
				pos_q[1] <= pos_y;
				pos_q[2] <= pos_z;
				draw_q   <= uniform_draw;
				ok_q     <= 1'b0;
				wr_q     <= s_ok_in && !action;
				e_old_q  <= '0;
				e_new_q  <= '0;
				cnt_q    <= '0;
			end
			S_WALL: begin
				cnt_q <= cnt_q + 6'd1;
				case (cnt_q)
					6'd1: wr2_q <= prod_q[63:0];
					6'd2, 6'd3: wr2_q <= wr2_q + prod_q[63:0];
					6'd4: ro2_q <= prod_q[61:0];
					default: ;
				endcase
			end
			S_OLDC: begin
				c_q[0]   <= ram_rdata[95:64];
				c_q[1]   <= ram_rdata[63:32];
				c_q[2]   <= ram_rdata[31:0];
				pass_q   <= 1'b0;
				i_q      <= '0;
				en_acc_q <= '0;
			end
			S_RD: begin
				if (i_done) begin
					if (!pass_q) begin
						e_old_q  <= en_acc_q;
						c_q      <= pos_q;
						pass_q   <= 1'b1;
						i_q      <= '0;
						en_acc_q <= '0;
					end else begin
						e_new_q <= en_acc_q;
					end
				end else if (i_is_s) begin
					i_q <= i_q + CW'(1);
				end
			end
			S_GET: begin
				o_q[0] <= ram_rdata[95:64];
				o_q[1] <= ram_rdata[63:32];
				o_q[2] <= ram_rdata[31:0];
				sh_q   <= first_sh;
			end
			S_IMG: begin
				if (far) begin
					if (img_last) begin
						i_q <= i_q + CW'(1);
					end else begin
						sh_q <= nsh;
					end
				end else begin
					for (int a = 0; a < 3; a++) begin
						da_q[a] <= dmag_w[a][16:0];
					end
					cnt_q <= '0;
				end
			end
			S_SQ: begin
				cnt_q <= cnt_q + 6'd1;
				case (cnt_q)
					6'd1: sq_acc_q <= prod_q[35:0];
					6'd2: sq_acc_q <= sq_sum;
					6'd3: begin
						if (sq_big) begin
							if (img_last) begin
								i_q <= i_q + CW'(1);
							end else begin
								sh_q <= nsh;
							end
						end else begin
							sq_x_q <= sq_sum;
							sq_r_q <= '0;
							sq_b_q <= FOUR_Q32;
						end
					end
					default: ;
				endcase
			end
			S_SQRT: begin
				sq_x_q <= sq_x_n;
				sq_r_q <= sq_r_n;
				sq_b_q <= sq_b_q >> 2;
			end
			S_ACC: begin
				en_acc_q <= en_sat;
				if (img_last) begin
					i_q <= i_q + CW'(1);
				end else begin
					sh_q <= nsh;
				end
			end
			S_CMP: begin
				if (e_new_q <= e_old_q) begin
					ok_q <= 1'b1;
					wr_q <= 1'b1;
				end else begin
					div_n_q <= {e_new_q - e_old_q, 16'h0000};
					div_r_q <= '0;
					div_d_q <= (kt_q == '0) ? 31'd1 : kt_q;
					cnt_q   <= '0;
					dmode_q <= 1'b0;
				end
			end
			S_DIV: begin
				div_n_q <= div_n_n;
				div_r_q <= div_r_n;
				cnt_q   <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					if (dmode_q) begin
						term_q   <= div_n_n[32:0];
						ex_acc_q <= ex_acc_n;
						if (k_q == 4'd14) begin
							p_q <= p_clamp;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end else if (m_big) begin
						p_q <= '0;
					end else begin
						m_q      <= div_n_n[20:16];
						f_q      <= div_n_n[15:0];
						term_q   <= P_ONE;
						ex_acc_q <= $signed({2'b00, P_ONE});
						k_q      <= 4'd1;
					end
				end
			end
			S_EDIV: begin
				div_n_q <= {31'b0, prod_q[48:16]};
				div_r_q <= '0;
				div_d_q <= {27'b0, k_q};
				cnt_q   <= '0;
				dmode_q <= 1'b1;
			end
			S_EPOW2: begin
				p_q <= p_round;
				m_q <= m_q - 5'd1;
			end
			S_DRAW: begin
				ok_q <= {1'b0, draw_q} <= p_q;
				wr_q <= {1'b0, draw_q} <= p_q;
			end
			S_FIN: if (fin_go) begin
				out_acc_q <= ok_q;
				out_eb_q  <= e_old_q;
				out_ea_q  <= e_new_q;
			end
			default: ;
		endcase
	end

	assign ram_we    = fin_go && wr_q;
	assign ram_raddr = (state_q == S_RDS) ? AW'(s_q) : i_q[AW-1:0];

	mssm_ram #(
		.WIDTH(3 * POS_W),
		.DEPTH(MAX_SPHERES)
	) u_pos_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(s_q)),
		.wdata({pos_q[0], pos_q[1], pos_q[2]}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	a_sqrt_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> $onehot(sq_b_q))
		else $error("square root step bit lost");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_r_q < div_d_q)
		else $error("divider remainder not below divisor");

	a_accept_rule: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && ok_q |-> (e_new_q <= e_old_q) || ({1'b0, draw_q} <= p_q))
		else $error("move accepted against acceptance rule");
`endif

endmodule

@@ dv/mssm_checker.sv @@
`timescale 1ns / 1ps
// Checker for the soft-sphere move block: watches the channels, predicts each outcome, compares.
module mssm_checker
	import mssm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  action,
	input  logic [7:0]            sphere_index,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic [31:0]           uniform_draw,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  accepted,
	input  logic [E_W-1:0]        energy_before,
	input  logic [E_W-1:0]        energy_after,
	output int                    errors,
	output int                    outstanding
);

	localparam int NSPH = MAX_SPHERES_DEF;
	localparam longint unsigned SAT = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic           acc;
		logic [E_W-1:0] eb;
		logic [E_W-1:0] ea;
	} outcome_t;

	outcome_t        outcomes[$];
	longint          store_x[NSPH];
	longint          store_y[NSPH];
	longint          store_z[NSPH];
	logic [30:0]     box[3];
	logic [30:0]     kt_reg;
	logic [30:0]     outer_r;
	logic [30:0]     inner_r;
	logic [7:0]      mode;
	logic [8:0]      count;

	assign outstanding = outcomes.size();

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pair_term(longint dx, longint dy, longint dz);
		longint unsigned ax, ay, az, r2, r, u;
		ax = absv(dx);
		ay = absv(dy);
		az = absv(dz);
		if (ax >= 131072 || ay >= 131072 || az >= 131072) return 0;
		r2 = ax * ax + ay * ay + az * az;
		if (r2 >= (64'd4 << 32)) return 0;
		r = isqrt(r2);
		u = 131072 - r;
		return (u * u) >> 18;
	endfunction

	function automatic bit axis_on(int a, longint c);
		return mode[a] && (2 * absv(c) + 4 * 65536 >= longint'(box[a]));
	endfunction

	function automatic longint unsigned energy_at(longint px, longint py, longint pz,
			int s, int n);
		bit             on[3];
		longint unsigned sum;
		longint         lx, ly, lz;
		on[0] = axis_on(0, px);
		on[1] = axis_on(1, py);
		on[2] = axis_on(2, pz);
		lx = longint'(box[0]);
		ly = longint'(box[1]);
		lz = longint'(box[2]);
		sum = 0;
		for (int i = 0; i < n; i++) begin
			if (i == s) continue;
			for (int a = -1; a <= 1; a++) begin
				if (a != 0 && !on[0]) continue;
				for (int b = -1; b <= 1; b++) begin
					if (b != 0 && !on[1]) continue;
					for (int c = -1; c <= 1; c++) begin
						if (c != 0 && !on[2]) continue;
						sum += pair_term(store_x[i] + a * lx - px,
							store_y[i] + b * ly - py, store_z[i] + c * lz - pz);
						if (sum > SAT) sum = SAT;
					end
				end
			end
		end
		return sum;
	endfunction

	function automatic longint unsigned neg_exp(longint unsigned x);
		longint unsigned m, f, term, p;
		longint          acc;
		m = x >> 16;
		f = x & 64'hFFFF;
		term = 64'd1 << 32;
		acc = longint'(64'd1 << 32);
		if (m >= 32) return 0;
		for (int k = 1; k <= 14; k++) begin
			term = ((term * f) >> 16) / k;
			acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > longint'(64'd1 << 32)) acc = longint'(64'd1 << 32);
		p = acc;
		for (longint unsigned k = 0; k < m; k++)
			p = (p * longint'(INV_E_Q32) + (64'd1 << 31)) >> 32;
		return p;
	endfunction

	function automatic outcome_t settle_move(logic act, logic [7:0] idx, longint px,
			longint py, longint pz, logic [31:0] draw);
		outcome_t        o;
		int              n;
		int              s;
		longint unsigned qx, qy, qz, r2, ow, iw, e_old, e_new, t, p;
		bit              ok;
		o = '0;
		s = idx;
		n = count > NSPH ? NSPH : count;
		if (!act) begin
			store_x[s] = px;
			store_y[s] = py;
			store_z[s] = pz;
			return o;
		end
		qx = px * px;
		qy = py * py;
		qz = pz * pz;
		r2 = qx + qy + qz;
		ow = longint'(outer_r) * longint'(outer_r);
		iw = longint'(inner_r) * longint'(inner_r);
		if (mode[6] && r2 > ow) return o;
		if (mode[7] && r2 < iw) return o;
		if (mode[3] && 2 * absv(px) > longint'(box[0])) return o;
		if (mode[4] && 2 * absv(py) > longint'(box[1])) return o;
		if (mode[5] && 2 * absv(pz) > longint'(box[2])) return o;
		e_old = energy_at(store_x[s], store_y[s], store_z[s], s, n);
		e_new = energy_at(px, py, pz, s, n);
		if (e_new <= e_old) begin
			ok = 1;
		end else begin
			t = (kt_reg == 0) ? 1 : kt_reg;
			p = neg_exp(((e_new - e_old) << 16) / t);
			ok = draw <= p;
		end
		if (ok) begin
			store_x[s] = px;
			store_y[s] = py;
			store_z[s] = pz;
		end
		o.acc = ok;
		o.eb = e_old[E_W-1:0];
		o.ea = e_new[E_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			box[0] <= 31'd1310720;
			box[1] <= 31'd1310720;
			box[2] <= 31'd1310720;
			kt_reg <= 31'd65536;
			mode <= '0;
			outer_r <= 31'd655360;
			inner_r <= 31'd196608;
			count <= 9'd1;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BOX_X:   box[0] = cfg_data;
					CFG_BOX_Y:   box[1] = cfg_data;
					CFG_BOX_Z:   box[2] = cfg_data;
					CFG_KT:      kt_reg = cfg_data;
					CFG_MODE:    mode = cfg_data[7:0];
					CFG_OUTER_R: outer_r = cfg_data;
					CFG_INNER_R: inner_r = cfg_data;
					CFG_COUNT:   count = cfg_data[8:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (outcomes.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected result acc=%0b eb=%h ea=%h", $realtime,
							accepted, energy_before, energy_after);
					errors <= errors + 1;
				end else begin
					want = outcomes.pop_front();
					if (want.acc !== accepted || want.eb !== energy_before
							|| want.ea !== energy_after) begin
						if (errors < 10)
							$display("%t mismatch exp acc=%0b eb=%h ea=%h got acc=%0b eb=%h ea=%h",
								$realtime, want.acc, want.eb, want.ea, accepted,
								energy_before, energy_after);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready)
				outcomes.push_back(settle_move(action, sphere_index, longint'(pos_x),
					longint'(pos_y), longint'(pos_z), uniform_draw));
		end
	end

endmodule

@@ dv/metropolis_soft_sphere_move_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the soft-sphere move block: stimulus, handshake pacing and verdict.
module metropolis_soft_sphere_move_tb;
	import mssm_pkg::*;

	localparam longint LIMIT = 60_000_000;
	localparam int ONE = 65536;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 0;
	logic                  in_ready;
	logic                  action = 0;
	logic [7:0]            sphere_index = '0;
	logic signed [31:0]    pos_x = '0;
	logic signed [31:0]    pos_y = '0;
	logic signed [31:0]    pos_z = '0;
	logic [31:0]           uniform_draw = '0;
	logic                  out_valid;
	logic                  out_ready = 0;
	logic                  accepted;
	logic [E_W-1:0]        energy_before;
	logic [E_W-1:0]        energy_after;
	int                    errors;
	int                    outstanding;
	bit                    gaps_on = 1;
	int                    cur_count = 1;
	longint                cycles = 0;

	metropolis_soft_sphere_move dut (.*);

	mssm_checker chk (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("metropolis_soft_sphere_move_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic reg_write(cfg_reg_t idx, logic [30:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
			logic [30:0] kt, logic [7:0] md, logic [30:0] orad, logic [30:0] irad,
			logic [8:0] cnt);
		reg_write(CFG_BOX_X, bx);
		reg_write(CFG_BOX_Y, by);
		reg_write(CFG_BOX_Z, bz);
		reg_write(CFG_KT, kt);
		reg_write(CFG_MODE, {23'd0, md});
		reg_write(CFG_OUTER_R, orad);
		reg_write(CFG_INNER_R, irad);
		reg_write(CFG_COUNT, {22'd0, cnt});
		cfg_we <= 0;
		cur_count = (cnt == 0) ? 1 : cnt;
		@(posedge clk);
	endtask

	task automatic send(logic act, logic [7:0] idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] draw);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		sphere_index <= idx;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		uniform_draw <= draw;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] near();
		return 32'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
	endfunction

	function automatic logic [31:0] coord();
		return ($urandom_range(0, 9) == 0) ? $urandom : near();
	endfunction

	function automatic logic [31:0] draw_val();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int num);
		logic [7:0] idx;
		for (int i = 0; i < num; i++) begin
			idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, cur_count - 1));
			send($urandom_range(0, 3) != 0, idx, coord(), coord(), coord(), draw_val());
		end
	endtask

	initial begin
		logic [30:0] bl;
		logic [7:0]  md;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// fill every store entry before any move reads it
		for (int i = 0; i < 256; i++) send(0, 8'(i), near(), near(), near(), $urandom);
		drain();
		configure(31'd20 * ONE, 31'd20 * ONE, 31'd20 * ONE, ONE, 8'h00, 31'd10 * ONE,
			31'd3 * ONE, 9'd4);
		send(0, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
		send(0, 8'd1, 32'd65536, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send(1, 8'd0, 32'd32768, 32'h0, 32'h0, 32'h0);
		send(1, 8'd2, 32'd98304, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send(1, 8'd3, 32'h0, 32'h0, 32'h0, 32'h0);
		send(1, 8'd200, 32'd40000, 32'd20000, 32'h0, 32'h8000_0000);
		send(1, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send(1, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		drain();
		// walls and periodic images in a tight box
		configure(31'd6 * ONE, 31'd6 * ONE, 31'd6 * ONE, 31'd1, 8'hFF, 31'd4 * ONE,
			31'd1 * ONE, 9'd5);
		send(1, 8'd0, 32'd2 * ONE, 32'h0, 32'h0, 32'h0);
		send(1, 8'd1, 32'd4 * ONE, 32'h0, 32'h0, 32'h0);
		send(1, 8'd2, 32'd100, 32'd100, 32'd100, 32'h0);
		send(1, 8'd3, 32'd5 * ONE, 32'd5 * ONE, 32'h0, 32'h0);
		send(1, 8'd4, 32'(-2 * ONE), 32'd2 * ONE, 32'd2 * ONE, 32'hFFFF_FFFF);
		drain();
		// zero temperature, extreme registers
		configure(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0, 8'h07, 31'h7FFF_FFFF,
			31'd0, 9'd3);
		send(1, 8'd0, near(), near(), near(), 32'h0);
		send(1, 8'd1, near(), near(), near(), 32'h1);
		drain();
		configure(31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF, 8'hC0, 31'd0, 31'h7FFF_FFFF, 9'd2);
		send(1, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
		send(1, 8'd1, near(), near(), near(), draw_val());
		drain();
		// whole store in use, a few slow moves
		configure(31'd20 * ONE, 31'd20 * ONE, 31'd20 * ONE, ONE, 8'h00, 31'd10 * ONE,
			31'd0, 9'd256);
		for (int i = 0; i < 3; i++)
			send(1, 8'($urandom_range(0, 255)), near(), near(), near(), draw_val());
		drain();
		configure(31'd20 * ONE, 31'd20 * ONE, 31'd20 * ONE, ONE, 8'h00, 31'd10 * ONE,
			31'd0, 9'h1FF);
		send(1, 8'd7, near(), near(), near(), draw_val());
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9) gaps_on = 0;
			bl = ($urandom_range(0, 1) == 0) ? 31'($urandom_range(6 * ONE, 24 * ONE))
				: 31'($urandom_range(0, 3) == 0 ? $urandom : 20 * ONE);
			md = $urandom;
			configure(bl, 31'($urandom_range(6 * ONE, 24 * ONE)), bl,
				31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4 * ONE)),
				md, 31'($urandom_range(2 * ONE, 12 * ONE)),
				31'($urandom_range(0, 2 * ONE)), 9'($urandom_range(1, 6)));
			random_items(95);
			drain();
		end
		if (errors == 0) begin
			$display("metropolis_soft_sphere_move_tb: clean");
		end else begin
			$display("metropolis_soft_sphere_move_tb: errors");
		end
		$finish;
	end

endmodule
